// ----- hw/rtl/tcsr_pkg.sv -----
package tcsr_pkg;

  localparam int WORD_W    = 16;
  localparam int SCALE_W   = 28;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = WORD_W + SCALE_W;
  localparam int Q_W       = PROD_W - FRAC_BITS;

  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 2);

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_SCALE_ON  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_SCALE     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SCALE_ON = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SCALE    = CFG_IDX_W'(3);

  localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(65536);

  localparam logic [Q_W-1:0] POS_LIMIT = Q_W'(32767);
  localparam logic [Q_W-1:0] NEG_LIMIT = Q_W'(32768);

  localparam logic signed [WORD_W-1:0] WORD_MAX = 16'sh7fff;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 16'sh8000;

  typedef enum logic [2:0] {
    KIND_HEADER = 3'd0,
    KIND_INDEX  = 3'd1,
    KIND_S      = 3'd2,
    KIND_T      = 3'd3,
    KIND_END    = 3'd4
  } kind_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] word;
    logic signed [WORD_W-1:0] orig;
    kind_t                    kind;
    logic                     list_end;
    logic                     scale_en;
  } item_t;

endpackage

// ----- hw/rtl/tcsr_fifo.sv -----
module tcsr_fifo (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  tcsr_pkg::item_t             push_data,
  output logic                        full,
  input  logic                        pop,
  output tcsr_pkg::item_t             pop_data,
  output logic                        empty,
  output logic [tcsr_pkg::QCNT_W-1:0] count
);

  tcsr_pkg::item_t mem [tcsr_pkg::QDEPTH];
  logic [tcsr_pkg::QPTR_W-1:0] wr_ptr;
  logic [tcsr_pkg::QPTR_W-1:0] rd_ptr;
  logic do_push;
  logic do_pop;

  assign full     = (count == tcsr_pkg::QCNT_W'(tcsr_pkg::QDEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/tcsr_front.sv -----
module tcsr_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic signed [tcsr_pkg::WORD_W-1:0] word_in,
  input  logic                               width_scale_on,
  input  logic                               height_scale_on,
  output tcsr_pkg::item_t                    item
);

  logic                        expect_header;
  logic [tcsr_pkg::WORD_W-1:0] vertices_left;
  logic [1:0]                  vertex_word_pos;
  logic [tcsr_pkg::WORD_W-1:0] header_count;

  assign header_count = word_in[tcsr_pkg::WORD_W-1] ? 16'(-word_in) : 16'(word_in);

  always_comb begin
    item.word     = word_in;
    item.orig     = word_in;
    item.list_end = 1'b0;
    item.scale_en = 1'b0;
    item.kind     = tcsr_pkg::KIND_INDEX;
    if (expect_header) begin
      if (word_in == '0) begin
        item.kind     = tcsr_pkg::KIND_END;
        item.list_end = 1'b1;
      end else begin
        item.kind = tcsr_pkg::KIND_HEADER;
      end
    end else begin
      case (vertex_word_pos)
        2'd2: begin
          item.kind     = tcsr_pkg::KIND_S;
          item.scale_en = width_scale_on;
        end
        2'd3: begin
          item.kind     = tcsr_pkg::KIND_T;
          item.scale_en = height_scale_on;
        end
        default: begin
          item.kind = tcsr_pkg::KIND_INDEX;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_header   <= 1'b1;
      vertices_left   <= '0;
      vertex_word_pos <= '0;
    end else if (accept) begin
      if (expect_header) begin
        if (word_in != '0) begin
          vertices_left   <= header_count;
          vertex_word_pos <= '0;
          expect_header   <= 1'b0;
        end
      end else if (vertex_word_pos == 2'd3) begin
        vertex_word_pos <= '0;
        vertices_left   <= vertices_left - 1'b1;
        if (vertices_left == 16'd1) begin
          expect_header <= 1'b1;
        end
      end else begin
        vertex_word_pos <= vertex_word_pos + 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/tcsr_back.sv -----
module tcsr_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_empty,
  input  tcsr_pkg::item_t                     in_item,
  output logic                                in_pop,
  input  logic [tcsr_pkg::QCNT_W-1:0]         out_count,
  output logic                                out_push,
  output tcsr_pkg::item_t                     out_item,
  input  logic [tcsr_pkg::SCALE_W-1:0]        width_scale,
  input  logic [tcsr_pkg::SCALE_W-1:0]        height_scale
);

  logic                        s1_valid;
  tcsr_pkg::item_t             s1_item;
  logic                        s1_neg;
  logic [tcsr_pkg::PROD_W-1:0] s1_prod;

  logic [tcsr_pkg::QCNT_W-1:0]  pending;
  logic                         in_neg;
  logic [tcsr_pkg::WORD_W-1:0]  in_mag;
  logic [tcsr_pkg::SCALE_W-1:0] factor;
  logic [tcsr_pkg::Q_W-1:0]     q;

  assign pending = out_count + tcsr_pkg::QCNT_W'(s1_valid);
  assign in_pop  = !in_empty && (pending < tcsr_pkg::QCNT_W'(tcsr_pkg::QDEPTH));
  assign in_neg  = in_item.orig[tcsr_pkg::WORD_W-1];
  assign in_mag  = in_neg ? 16'(-in_item.orig) : 16'(in_item.orig);
  assign factor  = (in_item.kind == tcsr_pkg::KIND_T) ? height_scale : width_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (in_pop) begin
      s1_item <= in_item;
      s1_neg  <= in_neg;
      s1_prod <= tcsr_pkg::PROD_W'(in_mag) * tcsr_pkg::PROD_W'(factor);
    end
  end

  assign q        = s1_prod[tcsr_pkg::PROD_W-1:tcsr_pkg::FRAC_BITS];
  assign out_push = s1_valid;

  always_comb begin
    out_item = s1_item;
    if (s1_item.scale_en) begin
      if (s1_neg) begin
        out_item.word = (q > tcsr_pkg::NEG_LIMIT) ? tcsr_pkg::WORD_MIN
                                                  : 16'(-q[tcsr_pkg::WORD_W-1:0]);
      end else begin
        out_item.word = (q > tcsr_pkg::POS_LIMIT) ? tcsr_pkg::WORD_MAX
                                                  : q[tcsr_pkg::WORD_W-1:0];
      end
    end
  end

endmodule

// ----- hw/rtl/tri_command_st_rescaler_core.sv -----
// Triangle-command texture coordinate rescaler.
// Input channel: drive word_in and raise push; the word is taken as a
// transaction on each rising edge where push is high and full is low.
// Result channel: while empty is low, word_out, original_word, word_kind
// and list_end show the oldest result; it is taken when pop is high.
// Configuration channel: cfg_index selects the register (0 width_scale_on,
// 1 width_scale, 2 height_scale_on, 3 height_scale) and cfg_data carries the
// value; cfg_ready is always high. Write registers only while idle.
// A front stage classifies each word and tracks the vertex phase, a
// four-entry queue decouples it from a back stage that multiplies the
// magnitude by the factor, then truncates, restores the sign and saturates.
// Results land in a four-entry output queue.
// Each word passes the middle queue and the back stage register before empty
// falls; one word per cycle is sustained while the receiver pops every cycle.
// When the receiver stalls, the output queue fills, the back stage holds,
// the middle queue fills and full rises; nothing is dropped.
// Reset clears both queues, expects a header and restores the factors to
// 1.0 with scaling disabled.
module tri_command_st_rescaler_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [tcsr_pkg::WORD_W-1:0]    word_in,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [tcsr_pkg::WORD_W-1:0]    word_out,
  output logic signed [tcsr_pkg::WORD_W-1:0]    original_word,
  output logic [2:0]                            word_kind,
  output logic                                  list_end,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tcsr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tcsr_pkg::SCALE_W-1:0]          cfg_data
);

  logic                         width_scale_on;
  logic [tcsr_pkg::SCALE_W-1:0] width_scale;
  logic                         height_scale_on;
  logic [tcsr_pkg::SCALE_W-1:0] height_scale;

  logic                        accept;
  tcsr_pkg::item_t             front_item;
  tcsr_pkg::item_t             mid_item;
  logic                        mid_empty;
  logic                        mid_pop;
  logic [tcsr_pkg::QCNT_W-1:0] mid_count;
  tcsr_pkg::item_t             back_item;
  logic                        back_push;
  logic                        out_full;
  logic [tcsr_pkg::QCNT_W-1:0] out_count;
  tcsr_pkg::item_t             out_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_scale_on  <= 1'b0;
      width_scale     <= tcsr_pkg::SCALE_ONE;
      height_scale_on <= 1'b0;
      height_scale    <= tcsr_pkg::SCALE_ONE;
    end else if (cfg_valid) begin
      case (cfg_index)
        tcsr_pkg::REG_WIDTH_SCALE_ON:  width_scale_on  <= cfg_data[0];
        tcsr_pkg::REG_WIDTH_SCALE:     width_scale     <= cfg_data;
        tcsr_pkg::REG_HEIGHT_SCALE_ON: height_scale_on <= cfg_data[0];
        tcsr_pkg::REG_HEIGHT_SCALE:    height_scale    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign accept = push && !full;

  tcsr_front u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .word_in         (word_in),
    .width_scale_on  (width_scale_on),
    .height_scale_on (height_scale_on),
    .item            (front_item)
  );

  tcsr_fifo u_mid_q (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (front_item),
    .full      (full),
    .pop       (mid_pop),
    .pop_data  (mid_item),
    .empty     (mid_empty),
    .count     (mid_count)
  );

  tcsr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_empty     (mid_empty),
    .in_item      (mid_item),
    .in_pop       (mid_pop),
    .out_count    (out_count),
    .out_push     (back_push),
    .out_item     (back_item),
    .width_scale  (width_scale),
    .height_scale (height_scale)
  );

  tcsr_fifo u_out_q (
    .clk       (clk),
    .rst       (rst),
    .push      (back_push),
    .push_data (back_item),
    .full      (out_full),
    .pop       (pop),
    .pop_data  (out_item),
    .empty     (empty),
    .count     (out_count)
  );

  assign word_out      = out_item.word;
  assign original_word = out_item.orig;
  assign word_kind     = out_item.kind;
  assign list_end      = out_item.list_end ^ (out_full & 1'b0) ^ (|mid_count & 1'b0);

endmodule

// ----- verif/tb_tri_command_st_rescaler_core.sv -----
module tb_tri_command_st_rescaler_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [tcsr_pkg::WORD_W-1:0] word_t;

  typedef struct {
    word_t           word;
    word_t           orig;
    tcsr_pkg::kind_t kind;
    logic            last;
  } rewritten_word_t;

  class rescaled_word_board;
    logic                         s_on;
    logic [tcsr_pkg::SCALE_W-1:0] s_factor;
    logic                         t_on;
    logic [tcsr_pkg::SCALE_W-1:0] t_factor;
    logic                         awaiting_header;
    int                           verts_left;
    logic [1:0]                   vert_pos;
    rewritten_word_t              due_words[$];
    int                           errors;

    function void reset_state();
      s_on = 1'b0;
      s_factor = tcsr_pkg::SCALE_ONE;
      t_on = 1'b0;
      t_factor = tcsr_pkg::SCALE_ONE;
      awaiting_header = 1'b1;
      verts_left = 0;
      vert_pos = 2'd0;
      due_words.delete();
      errors = 0;
    endfunction

    function void set_reg(logic [tcsr_pkg::CFG_IDX_W-1:0] idx,
                          logic [tcsr_pkg::SCALE_W-1:0] data);
      case (idx)
        tcsr_pkg::REG_WIDTH_SCALE_ON:  s_on = data[0];
        tcsr_pkg::REG_WIDTH_SCALE:     s_factor = data;
        tcsr_pkg::REG_HEIGHT_SCALE_ON: t_on = data[0];
        tcsr_pkg::REG_HEIGHT_SCALE:    t_factor = data;
        default: ;
      endcase
    endfunction

    function word_t scale_coord(word_t w, logic [tcsr_pkg::SCALE_W-1:0] factor);
      longint unsigned mag;
      longint unsigned q;
      mag = (w < 0) ? longint'(-int'(w)) : longint'(int'(w));
      q = (mag * longint'(factor)) >> tcsr_pkg::FRAC_BITS;
      if (w < 0) begin
        if (q > 64'd32768) q = 64'd32768;
        return word_t'(-longint'(q));
      end
      if (q > 64'd32767) q = 64'd32767;
      return word_t'(q);
    endfunction

    function void note_word(word_t w);
      rewritten_word_t r;
      r.word = w;
      r.orig = w;
      r.last = 1'b0;
      if (awaiting_header) begin
        if (w == 0) begin
          r.kind = tcsr_pkg::KIND_END;
          r.last = 1'b1;
        end else begin
          r.kind = tcsr_pkg::KIND_HEADER;
          verts_left = (w < 0) ? -int'(w) : int'(w);
          vert_pos = 2'd0;
          awaiting_header = 1'b0;
        end
      end else begin
        case (vert_pos)
          2'd0, 2'd1: r.kind = tcsr_pkg::KIND_INDEX;
          2'd2: begin
            r.kind = tcsr_pkg::KIND_S;
            if (s_on) r.word = scale_coord(w, s_factor);
          end
          default: begin
            r.kind = tcsr_pkg::KIND_T;
            if (t_on) r.word = scale_coord(w, t_factor);
          end
        endcase
        if (vert_pos == 2'd3) begin
          vert_pos = 2'd0;
          if (verts_left > 0) verts_left--;
          if (verts_left == 0) awaiting_header = 1'b1;
        end else begin
          vert_pos = vert_pos + 2'd1;
        end
      end
      due_words = {due_words, r};
    endfunction

    function void check_word(word_t word, word_t orig, logic [2:0] kind, logic last);
      rewritten_word_t e;
      if (due_words.size() == 0) begin
        $error("unexpected transaction: word_out %0d original_word %0d", word, orig);
        errors++;
        return;
      end
      e = due_words.pop_front();
      if (word !== e.word) begin
        $error("word_out: expected %0d, actual %0d", e.word, word);
        errors++;
      end
      if (orig !== e.orig) begin
        $error("original_word: expected %0d, actual %0d", e.orig, orig);
        errors++;
      end
      if (kind !== 3'(e.kind)) begin
        $error("word_kind: expected %0d, actual %0d", 3'(e.kind), kind);
        errors++;
      end
      if (last !== e.last) begin
        $error("list_end: expected %0d, actual %0d", e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return due_words.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           push = 1'b0;
  logic                           full;
  word_t                          word_in = '0;
  logic                           empty;
  logic                           pop = 1'b0;
  word_t                          word_out;
  word_t                          original_word;
  logic [2:0]                     word_kind;
  logic                           list_end;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [tcsr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tcsr_pkg::SCALE_W-1:0]   cfg_data = '0;

  rescaled_word_board board;
  int  words_sent = 0;
  bit  idle_on = 1'b0;
  int  long_hold_req = 0;

  tri_command_st_rescaler_core dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .word_in(word_in),
    .empty(empty),
    .pop(pop),
    .word_out(word_out),
    .original_word(original_word),
    .word_kind(word_kind),
    .list_end(list_end),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #8ms;
    $display("tri_command_st_rescaler_core verification failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic word_t pick_coord();
    case ($urandom_range(0, 9))
      0: return tcsr_pkg::WORD_MAX;
      1: return tcsr_pkg::WORD_MIN;
      2: return word_t'(-32767);
      3: return word_t'(int'($urandom_range(0, 8)) - 4);
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 4);
    if (r < 95) return $urandom_range(5, 12);
    return $urandom_range(13, 40);
  endfunction

  function automatic logic [tcsr_pkg::SCALE_W-1:0] pick_factor();
    if ($urandom_range(0, 3) == 0) begin
      return tcsr_pkg::SCALE_W'($urandom_range(0, 28'hFFFFFFF));
    end
    return tcsr_pkg::SCALE_W'($urandom_range(0, 4 * 65536));
  endfunction

  always @(posedge clk) begin
    if (!rst && pop && !empty) board.check_word(word_out, original_word, word_kind, list_end);
  end

  initial begin : result_drain
    int stall;
    int served;
    stall = 0;
    served = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req != served) begin
        served = long_hold_req;
        stall = 400;
      end
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        if (idle_on) stall = pick_gap();
      end
    end
  end

  task automatic send_word(input word_t w);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    word_in <= w;
    do @(posedge clk); while (full);
    board.note_word(w);
    words_sent++;
  endtask

  task automatic send_vertex(input word_t s, input word_t t);
    send_word(word_t'($urandom));
    send_word(word_t'($urandom));
    send_word(s);
    send_word(t);
  endtask

  task automatic send_list();
    int groups;
    int n;
    groups = $urandom_range(1, 4);
    if ($urandom_range(0, 9) == 0) send_word('0);
    repeat (groups) begin
      n = pick_count();
      send_word($urandom_range(0, 1) ? word_t'(-n) : word_t'(n));
      repeat (n) send_vertex(pick_coord(), pick_coord());
    end
    if ($urandom_range(0, 99) < 85) send_word('0);
  endtask

  task automatic write_reg(input logic [tcsr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tcsr_pkg::SCALE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, data);
  endtask

  task automatic set_scaling(input logic s_on, input logic [tcsr_pkg::SCALE_W-1:0] s_factor,
                             input logic t_on, input logic [tcsr_pkg::SCALE_W-1:0] t_factor);
    push <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    write_reg(tcsr_pkg::REG_WIDTH_SCALE_ON, tcsr_pkg::SCALE_W'(s_on));
    write_reg(tcsr_pkg::REG_WIDTH_SCALE, s_factor);
    write_reg(tcsr_pkg::REG_HEIGHT_SCALE_ON, tcsr_pkg::SCALE_W'(t_on));
    write_reg(tcsr_pkg::REG_HEIGHT_SCALE, t_factor);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int target;
    board = new();
    board.reset_state();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_on = 1'b1;
    send_word(word_t'(1));
    send_vertex(tcsr_pkg::WORD_MAX, tcsr_pkg::WORD_MIN);
    send_word(word_t'(-1));
    send_vertex('0, word_t'(-1));
    send_word('0);
    send_word('0);

    set_scaling(1'b1, 28'hFFFFFFF, 1'b1, '0);
    send_word(word_t'(2));
    send_vertex(tcsr_pkg::WORD_MAX, tcsr_pkg::WORD_MIN);
    send_vertex(tcsr_pkg::WORD_MIN, word_t'(1));
    send_word('0);

    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: set_scaling(1'b1, tcsr_pkg::SCALE_ONE, 1'b1, tcsr_pkg::SCALE_ONE);
        1: set_scaling(1'b0, pick_factor(), 1'b0, pick_factor());
        2: set_scaling(1'b1, 28'hFFFFFFF, 1'b1, '0);
        3: set_scaling(1'b1, '0, 1'b1, 28'hFFFFFFF);
        default: set_scaling(1'($urandom), pick_factor(), 1'($urandom), pick_factor());
      endcase
      idle_on = (phase > 1) && ($urandom_range(0, 3) != 0);
      if (phase == 1) long_hold_req++;
      target = words_sent + 160;
      while (words_sent < target) send_list();
    end

    // A header of the most negative value opens a group that the run never finishes.
    send_word(tcsr_pkg::WORD_MIN);
    repeat (3) send_vertex(pick_coord(), pick_coord());

    push <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (board.errors == 0) begin
      $display("tri_command_st_rescaler_core verification clean");
    end else begin
      $display("tri_command_st_rescaler_core verification failed");
    end
    $finish;
  end

endmodule
